// ===== hw/rtl/pss_pkg.sv =====
// Package for the PWM soft-start sequencer: payload types, register codes,
// state codes and reset values. No dependencies.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int unsigned FreqW   = 18;
  localparam int unsigned ParamW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivSteps = ParamW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [FreqW-1:0]  FreqMax          = '1;
  localparam logic [FreqW-1:0]  StartFreqRst     = FreqW'(75000);
  localparam logic [FreqW-1:0]  RunFreqRst       = FreqW'(40000);
  localparam logic [ParamW-1:0] StepFreqRst      = ParamW'(500);
  localparam logic [ParamW-1:0] StepIntervalRst  = ParamW'(50);
  localparam logic [ParamW-1:0] RampDurationRst  = ParamW'(3500);
  localparam logic [ParamW-1:0] BoostFreqRst     = ParamW'(5000);

  localparam logic [1:0] VerdictNormal = 2'd0;
  localparam logic [1:0] VerdictFault  = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_FREQ    = 3'd0,
    REG_RUN_FREQ      = 3'd1,
    REG_STEP_FREQ     = 3'd2,
    REG_STEP_INTERVAL = 3'd3,
    REG_RAMP_DURATION = 3'd4,
    REG_BOOST_FREQ    = 3'd5
  } pss_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } pss_state_e;

  typedef struct packed {
    logic [TimeW-1:0] now_time;
    logic [1:0]       verdict;
    logic             hv_confirmed;
  } pss_in_t;

  typedef struct packed {
    logic [FreqW-1:0] pwm_freq;
    logic             fault_out;
    logic             boosted;
  } pss_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [FreqW-1:0]   data;
  } pss_cfg_t;

  // operands for the serial divide-multiply unit
  typedef struct packed {
    logic [ParamW-1:0] dividend;
    logic [ParamW-1:0] divisor;
    logic [ParamW-1:0] mult;
  } pss_dm_req_t;

endpackage

// ===== hw/rtl/pss_chan_if.sv =====
// Valid/ready channel interface carrying one item of payload type T.
// Used with the payload structs of pss_pkg.
`timescale 1ns / 1ps

interface pss_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pss_divmul.sv =====
// Bit-serial unit: floor(dividend / divisor) * mult, one quotient bit per cycle,
// folded into a shift-add product as the bits appear. Depends on pss_pkg.
`timescale 1ns / 1ps

module pss_divmul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  pss_pkg::pss_dm_req_t        req_i,
  output logic                        done_o,
  output logic [2*pss_pkg::ParamW-1:0] prod_o
);

  localparam int unsigned W = pss_pkg::ParamW;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [pss_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]       rem_q, rem_d;
  logic [W-1:0]       dvd_q, dvd_d;
  logic [W-1:0]       div_q, div_d;
  logic [W-1:0]       mul_q, mul_d;
  logic [2*W-1:0]     acc_q, acc_d;

  logic [W:0]         sh;
  logic [W+1:0]       diff;
  logic               qbit;

  always_comb begin
    sh   = {rem_q, dvd_q[W-1]};
    diff = {1'b0, sh} - {2'b00, div_q};
    qbit = ~diff[W+1];

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    mul_d  = mul_q;
    acc_d  = acc_q;

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      mul_d  = req_i.mult;
      acc_d  = '0;
    end else if (busy_q) begin
      rem_d = qbit ? diff[W-1:0] : sh[W-1:0];
      dvd_d = {dvd_q[W-2:0], 1'b0};
      acc_d = {acc_q[2*W-2:0], 1'b0} + (qbit ? {{W{1'b0}}, mul_q} : '0);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pss_pkg::DivCntW'(pss_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    mul_q <= mul_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/pwm_soft_start_sequencer_unit.sv =====
// PWM soft-start sequencer with fault latch: top level.
// Depends on pss_pkg, pss_chan_if and pss_divmul.
// Each item runs the 16 serial divide steps of the divide-multiply unit, then
// the result is registered once the output slot is free; new items are taken
// only in idle. Async active-low reset restores configuration and sequencer
// state to power-on values, except elapsed time, HV flag and output data.
`timescale 1ns / 1ps

module pwm_soft_start_sequencer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  pss_chan_if.sink   in_i,
  pss_chan_if.source out_o,
  pss_chan_if.sink   cfg_i
);

  localparam int unsigned FW = pss_pkg::FreqW;
  localparam int unsigned PW = pss_pkg::ParamW;
  localparam int unsigned TW = pss_pkg::TimeW;

  // configuration
  logic [FW-1:0] start_freq_q, run_freq_q;
  logic [PW-1:0] step_freq_q, step_ivl_q, ramp_dur_q, boost_freq_q;

  // sequencer state
  pss_pkg::pss_state_e state_q, state_d;
  logic          in_fault_q, in_fault_d;
  logic          boost_q, boost_d;
  logic [TW-1:0] start_time_q, start_time_d;
  logic [FW-1:0] ramp_q, ramp_d;
  logic [FW-1:0] held_q, held_d;
  logic [FW-1:0] last_q, last_d;
  logic [TW-1:0] elapsed_q, elapsed_d;
  logic          hv_q, hv_d;

  logic               out_valid_q, out_valid_d;
  pss_pkg::pss_out_t  out_q, out_d;

  logic                 in_fire, enter_normal, past, fin_go;
  logic                 dm_done;
  logic [2*PW-1:0]      dm_prod;
  pss_pkg::pss_dm_req_t dm_req;
  logic [FW-1:0]        target, held_new;
  logic [FW:0]          bsum;

  assign in_i.ready  = (state_q == pss_pkg::ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign enter_normal = (in_i.data.verdict == pss_pkg::VerdictNormal) && in_fault_q;

  assign dm_req.dividend = elapsed_d[PW-1:0];
  assign dm_req.divisor  = (step_ivl_q == '0) ? PW'(1) : step_ivl_q;
  assign dm_req.mult     = step_freq_q;

  pss_divmul u_divmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .req_i   (dm_req),
    .done_o  (dm_done),
    .prod_o  (dm_prod)
  );

  assign fin_go = (state_q == pss_pkg::ST_FIN) && (!out_valid_q || out_o.ready);

  always_comb begin
    past     = elapsed_q >= {{(TW-PW){1'b0}}, ramp_dur_q};
    bsum     = {1'b0, ramp_q} + {{(FW+1-PW){1'b0}}, boost_freq_q};
    held_new = bsum[FW] ? pss_pkg::FreqMax : bsum[FW-1:0];
    if (past) begin
      target = run_freq_q;
    end else if (dm_prod >= {{(2*PW-FW){1'b0}}, start_freq_q}) begin
      target = '0;
    end else begin
      target = start_freq_q - dm_prod[FW-1:0];
    end

    state_d      = state_q;
    in_fault_d   = in_fault_q;
    boost_d      = boost_q;
    start_time_d = start_time_q;
    ramp_d       = ramp_q;
    held_d       = held_q;
    last_d       = last_q;
    elapsed_d    = elapsed_q;
    hv_d         = hv_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;

    case (state_q)
      pss_pkg::ST_IDLE: begin
        if (in_fire) begin
          hv_d      = in_i.data.hv_confirmed;
          elapsed_d = in_i.data.now_time - start_time_q;
          if (in_i.data.verdict == pss_pkg::VerdictFault) begin
            in_fault_d = 1'b1;
          end else if (enter_normal) begin
            in_fault_d   = 1'b0;
            boost_d      = 1'b0;
            start_time_d = in_i.data.now_time;
            ramp_d       = start_freq_q;
            held_d       = '0;
            last_d       = start_freq_q;
            elapsed_d    = '0;
          end
          state_d = pss_pkg::ST_RUN;
        end
      end
      pss_pkg::ST_RUN: begin
        if (dm_done) begin
          state_d = pss_pkg::ST_FIN;
        end
      end
      pss_pkg::ST_FIN: begin
        if (fin_go) begin
          if (!in_fault_q) begin
            if (!boost_q && !past && hv_q) begin
              boost_d = 1'b1;
              held_d  = held_new;
              last_d  = held_new;
            end else if (boost_q) begin
              last_d = held_q;
            end else begin
              ramp_d = target;
              last_d = target;
            end
          end
          out_d.pwm_freq  = last_d;
          out_d.fault_out = in_fault_q;
          out_d.boosted   = boost_d;
          out_valid_d     = 1'b1;
          state_d         = pss_pkg::ST_IDLE;
        end
      end
      default: state_d = pss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pss_pkg::ST_IDLE;
      in_fault_q   <= 1'b0;
      boost_q      <= 1'b0;
      start_time_q <= '0;
      ramp_q       <= pss_pkg::StartFreqRst;
      held_q       <= '0;
      last_q       <= pss_pkg::StartFreqRst;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      in_fault_q   <= in_fault_d;
      boost_q      <= boost_d;
      start_time_q <= start_time_d;
      ramp_q       <= ramp_d;
      held_q       <= held_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    hv_q      <= hv_d;
    out_q     <= out_d;
  end

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_freq_q <= pss_pkg::StartFreqRst;
      run_freq_q   <= pss_pkg::RunFreqRst;
      step_freq_q  <= pss_pkg::StepFreqRst;
      step_ivl_q   <= pss_pkg::StepIntervalRst;
      ramp_dur_q   <= pss_pkg::RampDurationRst;
      boost_freq_q <= pss_pkg::BoostFreqRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        pss_pkg::REG_START_FREQ:    start_freq_q <= cfg_i.data.data;
        pss_pkg::REG_RUN_FREQ:      run_freq_q   <= cfg_i.data.data;
        pss_pkg::REG_STEP_FREQ:     step_freq_q  <= cfg_i.data.data[PW-1:0];
        pss_pkg::REG_STEP_INTERVAL: step_ivl_q   <= cfg_i.data.data[PW-1:0];
        pss_pkg::REG_RAMP_DURATION: ramp_dur_q   <= cfg_i.data.data[PW-1:0];
        pss_pkg::REG_BOOST_FREQ:    boost_freq_q <= cfg_i.data.data[PW-1:0];
        default: ;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dm_done |-> state_q == pss_pkg::ST_RUN)
    else $error("divide unit finished outside the run state");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == pss_pkg::ST_RUN)
    else $error("accepted item did not start the divide unit");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pss_pkg::ST_FIN && out_valid_q && !out_o.ready) |=>
      (state_q == pss_pkg::ST_FIN && out_valid_q))
    else $error("pending result overwritten");

endmodule
